### design/shg_pkg.sv
// Shared definitions for the spatial hash grid: grid geometry, derived widths,
// request, result and status codes, and the command word passed from front to back.
// No dependencies.
`default_nettype none

package shg_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH   = 16;
  localparam int GRID_HEIGHT  = 16;
  localparam int BUCKET_DEPTH = 8;
  localparam int CELL_SHIFT   = 7;

  localparam int NUM_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int NUM_SLOTS = NUM_CELLS * BUCKET_DEPTH;

  // Field widths, fixed by the interface.
  localparam int ID_W  = 16;
  localparam int POS_W = 16;
  localparam int RAD_W = 15;
  localparam int CAP_W = 7;
  localparam int CAP_MAX = 64;

  // Derived widths.
  localparam int XB     = (GRID_WIDTH > 1)  ? $clog2(GRID_WIDTH)  : 1;
  localparam int YB     = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int CB     = (NUM_CELLS > 1)   ? $clog2(NUM_CELLS)   : 1;
  localparam int AB     = (NUM_SLOTS > 1)   ? $clog2(NUM_SLOTS)   : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  // Signed cell coordinate with room for the query window edges and grid limits.
  localparam int CRD_W  = (18 - CELL_SHIFT > 10) ? 18 - CELL_SHIFT : 10;

  localparam logic signed [CRD_W-1:0] X_LAST = CRD_W'(GRID_WIDTH - 1);
  localparam logic signed [CRD_W-1:0] Y_LAST = CRD_W'(GRID_HEIGHT - 1);

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;
  localparam int QC_W    = 2;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_ID     = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  // Insert status.
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Classified operation.
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_INS_OUT,
    OP_QUERY,
    OP_QEMPTY
  } op_t;

  // One classified command. For an insert, x0 and y0 hold the target cell.
  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] obj_id;
    logic [XB-1:0]   x0;
    logic [XB-1:0]   x1;
    logic [YB-1:0]   y0;
    logic [YB-1:0]   y1;
    logic [CAP_W-1:0] cap;
  } cmd_t;

endpackage

`default_nettype wire

### design/shg_front.sv
// Front end of the spatial hash grid: takes requests, maps positions to cells,
// clips the query window and classifies each request. Depends on shg_pkg.
`default_nettype none

module shg_front (
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_req_type,
  input  wire logic [shg_pkg::ID_W-1:0]   in_obj_id,
  input  wire logic signed [shg_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [shg_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [shg_pkg::RAD_W-1:0]  in_radius,
  input  wire logic [shg_pkg::CAP_W-1:0]  in_max_ids,
  input  wire logic                       q_full,
  output logic                            push,
  output shg_pkg::cmd_t                   cmd
);
  import shg_pkg::*;

  // Position to cell index, truncating toward zero.
  function automatic logic signed [CRD_W-1:0] cell_of(input logic signed [POS_W-1:0] p);
    logic [POS_W:0]     mag;
    logic [CRD_W-1:0]   c;
    mag = p[POS_W-1] ? ((POS_W+1)'(0) - {p[POS_W-1], p}) : {1'b0, p};
    c   = CRD_W'(mag >> CELL_SHIFT);
    cell_of = p[POS_W-1] ? -$signed(c) : $signed(c);
  endfunction

  logic signed [CRD_W-1:0] gx, gy, rad_c, x0, x1, y0, y1, x0c, x1c, y0c, y1c;
  logic [CRD_W-1:0]        rad_u;
  logic                    in_grid, win_empty;
  logic [CAP_W-1:0]        cap_c;

  assign gx    = cell_of(in_pos_x);
  assign gy    = cell_of(in_pos_y);
  assign rad_u = CRD_W'(in_radius >> CELL_SHIFT) + 1'b1;
  assign rad_c = $signed(rad_u);

  assign x0 = gx - rad_c;
  assign x1 = gx + rad_c;
  assign y0 = gy - rad_c;
  assign y1 = gy + rad_c;

  assign x0c = (x0 < 0) ? '0 : x0;
  assign y0c = (y0 < 0) ? '0 : y0;
  assign x1c = (x1 > X_LAST) ? X_LAST : x1;
  assign y1c = (y1 > Y_LAST) ? Y_LAST : y1;

  assign in_grid   = (gx >= 0) && (gx <= X_LAST) && (gy >= 0) && (gy <= Y_LAST);
  assign win_empty = (x0 > X_LAST) || (x1 < 0) || (y0 > Y_LAST) || (y1 < 0);
  assign cap_c     = (in_max_ids > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : in_max_ids;

  assign busy = q_full;

  always_comb begin
    cmd.obj_id = in_obj_id;
    cmd.cap    = cap_c;
    push       = start && !q_full;
    unique case (in_req_type)
      REQ_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      REQ_INSERT: begin
        cmd.op = in_grid ? OP_INSERT : OP_INS_OUT;
      end
      REQ_QUERY: begin
        cmd.op = (win_empty || cap_c == '0) ? OP_QEMPTY : OP_QUERY;
      end
      default: begin
        // Unknown request: taken and dropped.
        cmd.op = OP_CLEAR;
        push   = 1'b0;
      end
    endcase
    if (in_req_type == REQ_INSERT) begin
      cmd.x0 = XB'(gx);
      cmd.y0 = YB'(gy);
    end else begin
      cmd.x0 = XB'(x0c);
      cmd.y0 = YB'(y0c);
    end
    cmd.x1 = XB'(x1c);
    cmd.y1 = YB'(y1c);
  end

endmodule

`default_nettype wire

### design/shg_queue.sv
// Short command queue between the front and back of the spatial hash grid.
// Depends on shg_pkg.
`default_nettype none

module shg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire shg_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               q_vld,
  output logic               q_full,
  output shg_pkg::cmd_t      head
);
  import shg_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push, do_pop;

  assign q_vld   = (cnt_r != '0);
  assign q_full  = (cnt_r == QC_W'(Q_DEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/shg_back.sv
// Back end of the spatial hash grid: bucket fill and id stores, clear, insert
// and the query walk over cells and slots. Depends on shg_pkg.
`default_nettype none

module shg_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_vld,
  input  wire shg_pkg::cmd_t             head,
  output logic                           pop,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic [1:0]                     out_status,
  output logic [shg_pkg::ID_W-1:0]       out_found_id,
  output logic                           out_last
);
  import shg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_Q_RD,
    S_Q_CHK,
    S_Q_ID,
    S_Q_END
  } state_t;

  state_t            state_r;
  logic [XB-1:0]     x_r;
  logic [YB-1:0]     y_r;
  logic [FILL_W-1:0] slot_r, f_r;
  logic [CAP_W-1:0]  n_r;
  logic [ID_W-1:0]   pend_r;
  logic              pend_vld_r;
  logic              out_valid_r, out_last_r;
  logic [1:0]        out_kind_r, out_status_r;
  logic [ID_W-1:0]   out_found_id_r;

  logic [FILL_W-1:0] fill_mem_r [NUM_CELLS];
  logic [ID_W-1:0]   id_mem_r   [NUM_SLOTS];
  logic [FILL_W-1:0] fill_rd_r;
  logic [ID_W-1:0]   id_rd_r;
  logic [NUM_CELLS-1:0] vld_r;

  logic [CB-1:0]     cell_idx;
  logic [FILL_W-1:0] fill_cur, slot_sel;
  logic [AB-1:0]     id_raddr, id_waddr;
  logic [CAP_W-1:0]  n_nxt;
  logic              ins_we, clr_go, row_end, walk_end, more_slots;

  assign cell_idx = CB'(int'(y_r) * GRID_WIDTH + int'(x_r));
  // A cell whose valid bit is clear has an empty bucket.
  assign fill_cur = vld_r[cell_idx] ? fill_rd_r : '0;
  assign slot_sel = (state_r == S_Q_ID) ? slot_r + 1'b1 : '0;
  assign id_raddr = AB'(int'(cell_idx) * BUCKET_DEPTH + int'(slot_sel));
  assign id_waddr = AB'(int'(cell_idx) * BUCKET_DEPTH + int'(fill_cur));
  assign ins_we   = (state_r == S_INS_WR) && (fill_cur < FILL_W'(BUCKET_DEPTH));
  assign clr_go   = (state_r == S_IDLE) && q_vld && (head.op == OP_CLEAR);
  assign n_nxt    = n_r + 1'b1;
  assign row_end  = (x_r == head.x1);
  assign walk_end = row_end && (y_r == head.y1);
  assign more_slots = ((slot_r + 1'b1) < f_r);

  assign pop = ((state_r == S_IDLE) && q_vld &&
                ((head.op == OP_CLEAR) || (head.op == OP_INS_OUT) ||
                 (head.op == OP_QEMPTY))) ||
               (state_r == S_INS_WR) || (state_r == S_Q_END);

  // Fill counts and stored ids; both read ports are registered.
  always_ff @(posedge clk) begin
    fill_rd_r <= fill_mem_r[cell_idx];
    if (ins_we) begin
      fill_mem_r[cell_idx] <= fill_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    id_rd_r <= id_mem_r[id_raddr];
    if (ins_we) begin
      id_mem_r[id_waddr] <= head.obj_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr_go) begin
      vld_r <= '0;
    end else if (ins_we) begin
      vld_r[cell_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      x_r            <= '0;
      y_r            <= '0;
      slot_r         <= '0;
      f_r            <= '0;
      n_r            <= '0;
      pend_r         <= '0;
      pend_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      out_kind_r     <= KIND_CLEAR;
      out_status_r   <= ST_STORED;
      out_found_id_r <= '0;
      out_last_r     <= 1'b0;
    end else begin
      out_valid_r    <= 1'b0;
      out_status_r   <= ST_STORED;
      out_found_id_r <= '0;
      out_last_r     <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            unique case (head.op)
              OP_CLEAR: begin
                out_valid_r <= 1'b1;
                out_kind_r  <= KIND_CLEAR;
              end
              OP_INS_OUT: begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= KIND_INSERT;
                out_status_r <= ST_OUTSIDE;
              end
              OP_QEMPTY: begin
                out_valid_r <= 1'b1;
                out_kind_r  <= KIND_EMPTY;
              end
              OP_INSERT: begin
                x_r     <= head.x0;
                y_r     <= head.y0;
                state_r <= S_INS_RD;
              end
              OP_QUERY: begin
                x_r        <= head.x0;
                y_r        <= head.y0;
                n_r        <= '0;
                pend_vld_r <= 1'b0;
                state_r    <= S_Q_RD;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_WR;
        end
        S_INS_WR: begin
          out_valid_r  <= 1'b1;
          out_kind_r   <= KIND_INSERT;
          out_status_r <= ins_we ? ST_STORED : ST_FULL;
          state_r      <= S_IDLE;
        end
        S_Q_RD: begin
          state_r <= S_Q_CHK;
        end
        S_Q_CHK: begin
          f_r    <= fill_cur;
          slot_r <= '0;
          if (fill_cur != '0) begin
            state_r <= S_Q_ID;
          end else if (walk_end) begin
            state_r <= S_Q_END;
          end else begin
            if (row_end) begin
              x_r <= head.x0;
              y_r <= y_r + 1'b1;
            end else begin
              x_r <= x_r + 1'b1;
            end
            state_r <= S_Q_RD;
          end
        end
        S_Q_ID: begin
          // One id is held back so the final one can carry the last flag.
          if (pend_vld_r) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= KIND_ID;
            out_found_id_r <= pend_r;
            out_last_r     <= 1'b0;
          end
          pend_r     <= id_rd_r;
          pend_vld_r <= 1'b1;
          n_r        <= n_nxt;
          if (n_nxt == head.cap) begin
            state_r <= S_Q_END;
          end else if (more_slots) begin
            slot_r <= slot_r + 1'b1;
          end else if (walk_end) begin
            state_r <= S_Q_END;
          end else begin
            if (row_end) begin
              x_r <= head.x0;
              y_r <= y_r + 1'b1;
            end else begin
              x_r <= x_r + 1'b1;
            end
            state_r <= S_Q_RD;
          end
        end
        S_Q_END: begin
          out_valid_r <= 1'b1;
          if (pend_vld_r) begin
            out_kind_r     <= KIND_ID;
            out_found_id_r <= pend_r;
          end else begin
            out_kind_r <= KIND_EMPTY;
          end
          pend_vld_r <= 1'b0;
          state_r    <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_found_id_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

### design/spatial_hash_grid.sv
// Top level of the spatial hash grid: front end, command queue and back end.
// Depends on shg_pkg, shg_front, shg_queue and shg_back.
//
//   Channel   Handshake            Ports
//   request   start high, busy low in_req_type, in_obj_id, in_pos_x, in_pos_y,
//                                  in_radius, in_max_ids
//   result    out_valid strobe     out_kind, out_status, out_found_id, out_last
//
// A clear or an off-grid insert is answered by the back end at dispatch; any other
// insert is dispatched, reads the fill count, writes the id if it fits and reports.
// A query is dispatched, then reads and checks the fill count of every cell in
// its clipped window that is visited, returns each id found and ends with a
// closing step, as the walk over cells and slots in the back end goes. A query
// whose window misses the grid, or whose cap is zero, is answered at dispatch.
// Reset is synchronous and active low; it empties every bucket at once.
// The result side cannot stall; busy is high only while the two-entry queue is full.
`default_nettype none

module spatial_hash_grid (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic [shg_pkg::ID_W-1:0]        in_obj_id,
  input  wire logic signed [shg_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [shg_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [shg_pkg::RAD_W-1:0]       in_radius,
  input  wire logic [shg_pkg::CAP_W-1:0]       in_max_ids,
  output logic                                 out_valid,
  output logic [1:0]                           out_kind,
  output logic [1:0]                           out_status,
  output logic [shg_pkg::ID_W-1:0]             out_found_id,
  output logic                                 out_last
);
  import shg_pkg::*;

  // Classified command words flow from the front end into the queue, and the
  // back end works on the queue head, popping it once every result is out.
  cmd_t push_cmd, head;
  logic push, pop, q_vld, q_full;

  shg_front u_front (
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_obj_id   (in_obj_id),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_radius   (in_radius),
    .in_max_ids  (in_max_ids),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  shg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_vld    (q_vld),
    .q_full   (q_full),
    .head     (head)
  );

  // The back end holds both stores: a fill count per cell, backed by one valid
  // bit per cell so that a clear empties every bucket at once, and the id
  // store, whose unwritten entries are never returned.
  shg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_status   (out_status),
    .out_found_id (out_found_id),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

### design/shg_checker.sv
// Port-level checks for the spatial hash grid, bound to the top level.
// Depends on shg_pkg and spatial_hash_grid.
`default_nettype none

module shg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_kind,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_found_id,
  input wire logic        out_last
);
  import shg_pkg::*;

  // Clears, insert reports and empty query results are single words.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CLEAR || out_kind == KIND_INSERT ||
                  out_kind == KIND_EMPTY) |-> out_last && out_found_id == 16'd0)
    else $error("single-word result without last flag or with an id");

  // Only insert reports carry a status.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_INSERT |-> out_status == ST_STORED)
    else $error("status set on a non-insert result");

  // A query still in progress is not followed at once by another request's word.
  a_query_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ID && !out_last |=>
      !(out_valid && (out_kind == KIND_CLEAR || out_kind == KIND_INSERT ||
                      out_kind == KIND_EMPTY)))
    else $error("query interrupted before its last id");

  // Nothing comes out straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity straight after reset");

endmodule

bind spatial_hash_grid shg_checker u_shg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_kind     (out_kind),
  .out_status   (out_status),
  .out_found_id (out_found_id),
  .out_last     (out_last)
);

`default_nettype wire

### tb/shg_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the spatial hash grid testbench: a software copy of the bucket store
// that works out the result words of every accepted request and checks them in order.
// Depends on shg_pkg for the geometry and the request, kind and status codes.
package shg_sb_pkg;
  import shg_pkg::*;

  // The block ignores this request code.
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic [ID_W-1:0] found_id;
    logic            last;
  } result_word_t;

  class grid_scoreboard;
    int unsigned     bucket_count [NUM_CELLS];
    logic [ID_W-1:0] bucket_slot  [NUM_SLOTS];
    result_word_t    due_words [$];
    int unsigned     mismatches;

    function new();
      foreach (bucket_count[c]) bucket_count[c] = 0;
      mismatches = 0;
    endfunction

    // Cell coordinate of a Q11.4 position; division truncates toward zero.
    function int cell_coord(logic signed [POS_W-1:0] p);
      int v;
      v = p;
      if (v < 0) return -((-v) >> CELL_SHIFT);
      return v >> CELL_SHIFT;
    endfunction

    function void add_word(logic [1:0] kind, logic [1:0] status,
                           logic [ID_W-1:0] found_id, logic last);
      result_word_t w;
      w.kind     = kind;
      w.status   = status;
      w.found_id = found_id;
      w.last     = last;
      due_words.push_back(w);
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction

    // Updates the bucket copy for one accepted request and queues its result words.
    function void note_request(logic [1:0] req, logic [ID_W-1:0] id,
                               logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                               logic [RAD_W-1:0] rad, logic [CAP_W-1:0] cap);
      int gx, gy, r, x_lo, x_hi, y_lo, y_hi, id_cap, n, c, x, y, s;
      logic [1:0] st;
      result_word_t w;
      gx = cell_coord(px);
      gy = cell_coord(py);
      case (req)
        REQ_CLEAR: begin
          foreach (bucket_count[i]) bucket_count[i] = 0;
          add_word(KIND_CLEAR, '0, '0, 1'b1);
        end
        REQ_INSERT: begin
          if (gx < 0 || gy < 0 || gx >= GRID_WIDTH || gy >= GRID_HEIGHT) begin
            st = ST_OUTSIDE;
          end else begin
            c = gy * GRID_WIDTH + gx;
            if (bucket_count[c] < BUCKET_DEPTH) begin
              bucket_slot[c * BUCKET_DEPTH + bucket_count[c]] = id;
              bucket_count[c]++;
              st = ST_STORED;
            end else begin
              st = ST_FULL;
            end
          end
          add_word(KIND_INSERT, st, '0, 1'b1);
        end
        REQ_QUERY: begin
          r      = int'(rad >> CELL_SHIFT) + 1;
          id_cap = (cap > CAP_MAX) ? CAP_MAX : int'(cap);
          x_lo   = (gx - r < 0) ? 0 : gx - r;
          y_lo   = (gy - r < 0) ? 0 : gy - r;
          x_hi   = (gx + r > GRID_WIDTH - 1)  ? GRID_WIDTH - 1  : gx + r;
          y_hi   = (gy + r > GRID_HEIGHT - 1) ? GRID_HEIGHT - 1 : gy + r;
          n      = 0;
          for (y = y_lo; y <= y_hi && n < id_cap; y++) begin
            for (x = x_lo; x <= x_hi && n < id_cap; x++) begin
              c = y * GRID_WIDTH + x;
              for (s = 0; s < int'(bucket_count[c]) && n < id_cap; s++) begin
                add_word(KIND_ID, '0, bucket_slot[c * BUCKET_DEPTH + s], 1'b0);
                n++;
              end
            end
          end
          if (n == 0) begin
            add_word(KIND_EMPTY, '0, '0, 1'b1);
          end else begin
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words.push_back(w);
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compares one result word with the oldest one still due.
    function void check_word(logic [1:0] kind, logic [1:0] status,
                             logic [ID_W-1:0] found_id, logic last);
      result_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected result word: kind %0d, found_id %0d", kind, found_id);
        mismatches++;
        return;
      end
      w = due_words.pop_front();
      if (kind !== w.kind) begin
        $error("out_kind: expected %0d, got %0d", w.kind, kind);
        mismatches++;
      end
      if (status !== w.status) begin
        $error("out_status: expected %0d, got %0d", w.status, status);
        mismatches++;
      end
      if (found_id !== w.found_id) begin
        $error("out_found_id: expected %0d, got %0d", w.found_id, found_id);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("out_last: expected %0d, got %0d", w.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### tb/spatial_hash_grid_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for spatial_hash_grid: directed corner cases, then random
// clears, inserts and queries, every result word checked against a scoreboard.
// Depends on shg_pkg, shg_sb_pkg and the spatial_hash_grid RTL.
module spatial_hash_grid_tb;
  import shg_pkg::*;
  import shg_sb_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_req_type;
  logic [ID_W-1:0]         in_obj_id;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic [RAD_W-1:0]        in_radius;
  logic [CAP_W-1:0]        in_max_ids;
  logic                    out_valid;
  logic [1:0]              out_kind;
  logic [1:0]              out_status;
  logic [ID_W-1:0]         out_found_id;
  logic                    out_last;

  grid_scoreboard grid_sb;

  // While this is set the sender never pauses between words.
  logic free_run;

  spatial_hash_grid uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_obj_id    (in_obj_id),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_radius    (in_radius),
    .in_max_ids   (in_max_ids),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_status   (out_status),
    .out_found_id (out_found_id),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. The slowest correct run, walking the whole grid on every query over
  // roughly 300 words, is well under a millisecond; four milliseconds leaves
  // several times that margin.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The result side cannot be held off, so every strobed word is checked at the
  // edge that ends its cycle. Words seen during reset are of no interest.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      grid_sb.check_word(out_kind, out_status, out_found_id, out_last);
    end
  end

  // Presents one request word from a falling edge and holds it until the block
  // takes it, that is until a rising edge finds busy low. Only then does the
  // scoreboard learn of it. Now and then the sender drops start and pauses.
  task automatic send_word(input logic [1:0] req, input logic [ID_W-1:0] id,
                           input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py,
                           input logic [RAD_W-1:0] rad, input logic [CAP_W-1:0] cap);
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_obj_id   <= id;
    in_pos_x    <= px;
    in_pos_y    <= py;
    in_radius   <= rad;
    in_max_ids  <= cap;
    do @(posedge clk); while (busy);
    grid_sb.note_request(req, id, px, py, rad, cap);
    if (!free_run && $urandom_range(0, 99) < 6) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Positions cluster round the first two cells in each direction, so that buckets
  // fill up and queries find plenty; the rest spread over the grid and its margins,
  // or over the whole signed range.
  function automatic logic signed [POS_W-1:0] pick_pos();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      v = int'($urandom_range(0, 295)) - 40;
    end else if (sel < 85) begin
      v = int'($urandom_range(0, 2175)) - 64;
    end else begin
      v = int'($urandom);
    end
    return POS_W'(v);
  endfunction

  initial begin
    int               done;
    int               pick;
    logic [1:0]       req;
    logic [RAD_W-1:0] rad;
    logic [CAP_W-1:0] cap;

    grid_sb     = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_CLEAR;
    in_obj_id   = '0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_radius   = '0;
    in_max_ids  = '0;
    free_run    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A query on the freshly reset grid must come back empty.
    send_word(REQ_QUERY, 16'h0000, 16'sd0, 16'sd0, 15'd0, 7'd64);
    // Lowest and highest ids; a small negative position truncates into cell 0.
    send_word(REQ_INSERT, 16'h0000, 16'sd0, 16'sd0, 15'd0, 7'd0);
    send_word(REQ_INSERT, 16'hFFFF, -16'sd1, -16'sd1, 15'd0, 7'd0);
    // Positions just off the grid or at field extremes are dropped; 2047 is kept.
    send_word(REQ_INSERT, 16'h1234, -16'sd128, 16'sd0, 15'd0, 7'd0);
    send_word(REQ_INSERT, 16'h5678, 16'sh7FFF, 16'sh7FFF, 15'd0, 7'd0);
    send_word(REQ_INSERT, 16'hA5A5, 16'sd2047, 16'sd2047, 15'd0, 7'd0);
    send_word(REQ_INSERT, 16'h0F0F, 16'sh8000, 16'sd5, 15'd0, 7'd0);
    send_word(REQ_INSERT, 16'hF0F0, 16'sd2048, 16'sd0, 15'd0, 7'd0);
    // Fill cell 0 to its depth; the last of these finds the bucket full.
    for (int k = 0; k < 7; k++) begin
      send_word(REQ_INSERT, 16'h0100 + 16'(k), 16'sd100, 16'sd50, 15'd0, 7'd0);
    end
    // A cap of zero gives an empty result, whatever the window holds.
    send_word(REQ_QUERY, 16'h0000, 16'sd0, 16'sd0, 15'h7FFF, 7'd0);
    // A cap above 64 behaves as 64; the widest radius covers the whole grid.
    send_word(REQ_QUERY, 16'hFFFF, 16'sd1024, 16'sd1024, 15'h7FFF, 7'h7F);
    // A small cap cuts the list short, with the last word marked.
    send_word(REQ_QUERY, 16'h0000, 16'sd0, 16'sd0, 15'd0, 7'd3);
    // Windows that miss the grid entirely, beyond either corner.
    send_word(REQ_QUERY, 16'h0000, 16'sh7FFF, 16'sh7FFF, 15'd0, 7'd64);
    send_word(REQ_QUERY, 16'h0000, -16'sd2047, -16'sd2047, 15'd127, 7'd64);
    // A negative centre close to the origin still finds cell 0.
    send_word(REQ_QUERY, 16'h0000, -16'sd100, -16'sd100, 15'd0, 7'd64);
    // The unused request code must be swallowed without a word or a change of state.
    send_word(REQ_IGNORED, 16'hBEEF, 16'sd0, 16'sd0, 15'd0, 7'd64);
    send_word(REQ_QUERY, 16'h0000, 16'sd0, 16'sd0, 15'd0, 7'd64);
    // Clear, then a whole-grid query must find nothing.
    send_word(REQ_CLEAR, 16'h0000, 16'sd0, 16'sd0, 15'd0, 7'd0);
    send_word(REQ_QUERY, 16'h0000, 16'sd0, 16'sd0, 15'h7FFF, 7'd64);

    // Random part. Inserts and queries dominate and clears are rare, so buckets
    // have time to fill. Ignored words do not count towards the total, and for a
    // stretch in the middle the sender runs flat out.
    done = 0;
    while (done < 250) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        req = REQ_CLEAR;
      end else if (pick < 52) begin
        req = REQ_INSERT;
      end else if (pick < 96) begin
        req = REQ_QUERY;
      end else begin
        req = REQ_IGNORED;
      end
      // Most radii reach one or two cells; a few span much more, and wide windows
      // are slow, so they are kept rare.
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        rad = RAD_W'($urandom_range(0, 255));
      end else if (pick < 95) begin
        rad = RAD_W'($urandom_range(0, 1023));
      end else begin
        rad = RAD_W'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        cap = CAP_W'($urandom_range(1, 64));
      end else if (pick < 85) begin
        cap = CAP_W'($urandom_range(0, 4));
      end else begin
        cap = CAP_W'($urandom_range(65, 127));
      end
      free_run = (done >= 100 && done < 170);
      send_word(req, ID_W'($urandom), pick_pos(), pick_pos(), rad, cap);
      if (req != REQ_IGNORED) done++;
    end

    @(negedge clk);
    start <= 1'b0;
    // Wait for every outstanding word, then a little longer so that any stray
    // extra word would still be caught.
    while (grid_sb.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (grid_sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
